// ===== sv/alternating_run_parity_extractor_defines.svh =====
// Assertion macros for the alternating run parity extractor checker.
// No dependencies; included by the checker file only.
`ifndef ALTERNATING_RUN_PARITY_EXTRACTOR_DEFINES_SVH
`define ALTERNATING_RUN_PARITY_EXTRACTOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define ARPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ARPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/arpe_pkg.sv =====
// Package for the alternating run parity extractor: widths, register indexes
// and defaults. No dependencies.
package arpe_pkg;

  localparam int CNT_W   = 7;   // run counter and run length width
  localparam int CFG_W   = 7;   // widest configuration register
  localparam int CFG_A_W = 1;   // configuration index width

  localparam int MAX_RUN_DEF = 64;
  localparam int MIN_RUN     = 2;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_ZERO_RUN = 1'b0,
    CFG_ONE_RUN  = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] ZERO_RUN_RST = 7'd4;
  localparam logic [CFG_W-1:0] ONE_RUN_RST  = 7'd4;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

endpackage

// ===== sv/alternating_run_parity_extractor.sv =====
// Alternating run parity extractor: one bit per transaction, marker run search
// and segment parity, with a two-entry result buffer. Depends on arpe_pkg.
//
// Takes one data bit per clock cycle while in_stall is low, with a combinational
// update of the run counter and segment parity feeding the result register. The
// bit that completes a marker run registers its result into the output register,
// or into the skid entry while the output register holds a result not yet taken,
// so input keeps flowing while a result waits; in_stall rises only once both
// entries hold results. Configuration writes take effect on the next transaction.
module alternating_run_parity_extractor #(
  parameter int MAX_RUN = arpe_pkg::MAX_RUN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [arpe_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [arpe_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_data_bit,
  input  logic                         in_block_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_extracted_bit
);

  localparam logic [arpe_pkg::CNT_W-1:0] RunMax = arpe_pkg::CNT_W'(MAX_RUN);
  localparam logic [arpe_pkg::CNT_W-1:0] RunMin = arpe_pkg::CNT_W'(arpe_pkg::MIN_RUN);

  logic [arpe_pkg::CFG_W-1:0] zero_len_r, one_len_r;

  logic                       first_found_r, first_found_nxt;
  logic                       wanted_r, wanted_nxt;
  logic                       prev_bit_r, prev_bit_nxt;
  logic                       seg_empty_r, seg_empty_nxt;
  logic [arpe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       parity_r, parity_nxt;

  logic out_valid_r, skid_valid_r;
  logic out_bit_r, skid_bit_r;

  // state after an optional block start
  logic                       s_found, s_wanted, s_prev, s_empty, s_par;
  logic [arpe_pkg::CNT_W-1:0] s_cnt, cnt_inc, cnt_upd, len_raw, run_len;
  logic                       run_value, par_upd, hit, result;
  logic                       accept, out_take;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_len_r <= arpe_pkg::ZERO_RUN_RST;
      one_len_r  <= arpe_pkg::ONE_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        arpe_pkg::CFG_ZERO_RUN: zero_len_r <= cfg_wdata;
        arpe_pkg::CFG_ONE_RUN:  one_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_found  = in_block_start ? 1'b0 : first_found_r;
    s_wanted = in_block_start ? 1'b0 : wanted_r;
    s_prev   = in_block_start ? 1'b0 : prev_bit_r;
    s_empty  = in_block_start ? 1'b1 : seg_empty_r;
    s_cnt    = in_block_start ? '0   : cnt_r;
    s_par    = in_block_start ? 1'b0 : parity_r;

    par_upd = s_par ^ in_data_bit;
    cnt_inc = (s_cnt == arpe_pkg::CNT_SAT) ? s_cnt : s_cnt + 1'b1;

    if (!s_found) begin
      cnt_upd   = (!s_empty && (in_data_bit == s_prev)) ? cnt_inc
                                                        : arpe_pkg::CNT_W'(1);
      run_value = in_data_bit;
    end else begin
      cnt_upd   = (in_data_bit == s_wanted) ? cnt_inc : '0;
      run_value = s_wanted;
    end

    // clamp the configured length into the legal run range
    len_raw = run_value ? one_len_r : zero_len_r;
    if (len_raw < RunMin)      run_len = RunMin;
    else if (len_raw > RunMax) run_len = RunMax;
    else                       run_len = len_raw;

    hit    = (cnt_upd != '0) && (run_value == in_data_bit) && (cnt_upd >= run_len);
    result = par_upd ^ (run_value & cnt_upd[0]);

    if (hit) begin
      first_found_nxt = 1'b1;
      wanted_nxt      = ~run_value;
      prev_bit_nxt    = 1'b0;
      seg_empty_nxt   = 1'b1;
      cnt_nxt         = '0;
      parity_nxt      = 1'b0;
    end else begin
      first_found_nxt = s_found;
      wanted_nxt      = s_wanted;
      prev_bit_nxt    = s_found ? s_prev : in_data_bit;
      seg_empty_nxt   = 1'b0;
      cnt_nxt         = cnt_upd;
      parity_nxt      = par_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_found_r <= 1'b0;
      wanted_r      <= 1'b0;
      prev_bit_r    <= 1'b0;
      seg_empty_r   <= 1'b1;
      cnt_r         <= '0;
      parity_r      <= 1'b0;
    end else if (accept) begin
      first_found_r <= first_found_nxt;
      wanted_r      <= wanted_nxt;
      prev_bit_r    <= prev_bit_nxt;
      seg_empty_r   <= seg_empty_nxt;
      cnt_r         <= cnt_nxt;
      parity_r      <= parity_nxt;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept && hit) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_bit_r <= skid_bit_r;
      end
    end else if (accept && hit) begin
      if (out_valid_r && !out_take) begin
        skid_bit_r <= result;
      end else begin
        out_bit_r <= result;
      end
    end
  end

  assign in_stall          = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_extracted_bit = out_bit_r;

endmodule

// ===== sv/arpe_checker.sv =====
// Port-level checker for the alternating run parity extractor, bound into the
// extractor module. Depends on alternating_run_parity_extractor_defines.svh.
`include "alternating_run_parity_extractor_defines.svh"

module arpe_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_extracted_bit
);

  `ARPE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_extracted_bit), "stalled result dropped or changed")
  `ARPE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown right after reset")
  `ARPE_ASSERT(a_result_cause, $rose(out_valid) |-> $past(in_valid && !in_stall), "result without an accepted transaction")
  `ARPE_ASSERT(a_stall_full, in_stall |-> out_valid, "input stalled with empty output register")

endmodule

bind alternating_run_parity_extractor arpe_checker u_arpe_checker (.*);

// ===== test/alternating_run_parity_extractor_test.sv =====
// Testbench for alternating_run_parity_extractor: random and directed bit streams, with
// a scoreboard class that predicts the segment parity after each marker run.
// Depends on arpe_pkg and the extractor RTL only.
`timescale 1ns / 1ps

module alternating_run_parity_extractor_test;

  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_PHASES  = 10;

  class marker_parity_board;
    logic [arpe_pkg::CFG_W-1:0] zero_len;
    logic [arpe_pkg::CFG_W-1:0] one_len;
    bit                         found;
    bit                         wanted;
    bit                         prev_bit;
    bit                         empty;
    bit                         parity;
    logic [arpe_pkg::CNT_W-1:0] run_cnt;
    bit                         expected_parity[$];
    int                         errors;

    function new();
      zero_len = arpe_pkg::ZERO_RUN_RST;
      one_len  = arpe_pkg::ONE_RUN_RST;
      errors   = 0;
      clear_search();
    endfunction

    function void clear_search();
      found    = 1'b0;
      wanted   = 1'b0;
      prev_bit = 1'b0;
      empty    = 1'b1;
      run_cnt  = '0;
      parity   = 1'b0;
    endfunction

    function int run_target(bit v);
      int len;
      len = v ? int'(one_len) : int'(zero_len);
      if (len < arpe_pkg::MIN_RUN) len = arpe_pkg::MIN_RUN;
      if (len > arpe_pkg::MAX_RUN_DEF) len = arpe_pkg::MAX_RUN_DEF;
      return len;
    endfunction

    function void note_bit(bit d, bit s);
      bit rv;
      if (s) clear_search();
      parity ^= d;
      if (!found) begin
        if (!empty && d == prev_bit) begin
          if (run_cnt != arpe_pkg::CNT_SAT) run_cnt++;
        end else begin
          run_cnt = arpe_pkg::CNT_W'(1);
        end
        prev_bit = d;
        rv = d;
      end else begin
        if (d == wanted) begin
          if (run_cnt != arpe_pkg::CNT_SAT) run_cnt++;
        end else begin
          run_cnt = '0;
        end
        rv = wanted;
      end
      empty = 1'b0;
      if (run_cnt != 0 && rv == d && run_cnt >= run_target(rv)) begin
        // ones of the run itself are not part of the segment
        expected_parity.push_back(parity ^ (rv & run_cnt[0]));
        found    = 1'b1;
        wanted   = ~rv;
        prev_bit = 1'b0;
        empty    = 1'b1;
        run_cnt  = '0;
        parity   = 1'b0;
      end
    endfunction

    function void check_bit(logic got);
      bit want;
      if (expected_parity.size() == 0) begin
        errors++;
        $display("%0t: extracted_bit expected none actual %b", $time, got);
        return;
      end
      want = expected_parity.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: extracted_bit expected %0b actual %b", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_parity.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [arpe_pkg::CFG_A_W-1:0]   cfg_addr = arpe_pkg::CFG_ZERO_RUN;
  logic [arpe_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_data_bit = 1'b0;
  logic                           in_block_start = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_extracted_bit;

  marker_parity_board   sb = new();
  bit                   calm = 1'b0;
  bit                   next_marker = 1'b0;
  int                   items_sent = 0;
  int                   quiet_cycles = 0;

  alternating_run_parity_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_bit       (in_data_bit),
    .in_block_start    (in_block_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_extracted_bit (out_extracted_bit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  always @(posedge clk) begin
    out_stall <= roll_idle();
  end

  // Monitor both channels and count cycles with no progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_bit(in_data_bit, in_block_start);
      if (out_valid && !out_stall) sb.check_bit(out_extracted_bit);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_bit(input bit d, input bit s);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_bit    <= d;
    in_block_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_run(input bit v, input int n);
    repeat (n) send_bit(v, 1'b0);
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // a bit that completes no run may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lengths(input logic [arpe_pkg::CFG_W-1:0] z,
                               input logic [arpe_pkg::CFG_W-1:0] o);
    cfg_we    <= 1'b1;
    cfg_addr  <= arpe_pkg::CFG_ZERO_RUN;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_addr  <= arpe_pkg::CFG_ONE_RUN;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.zero_len = z;
    sb.one_len  = o;
  endtask

  task automatic run_phase(input int n_items, input int max_pay);
    int first;
    int kind;
    int target;
    bit s;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        // random segment closed by a marker run, sometimes overlong
        repeat ($urandom_range(max_pay)) send_bit(1'($urandom_range(1)), 1'b0);
        target = sb.run_target(next_marker);
        if ($urandom_range(3) == 0) target += int'($urandom_range(1, 3));
        send_run(next_marker, target);
        next_marker = ~next_marker;
      end else if (kind < 86) begin
        repeat ($urandom_range(1, 8)) begin
          s = ($urandom_range(15) == 0);
          send_bit(1'($urandom_range(1)), s);
          if (s) next_marker = 1'($urandom_range(1));
        end
      end else if (kind < 94) begin
        // marker run broken one bit short
        send_run(next_marker, sb.run_target(next_marker) - 1);
        send_bit(~next_marker, 1'b0);
      end else begin
        send_bit(1'($urandom_range(1)), 1'b1);
        next_marker = 1'($urandom_range(1));
      end
    end
    // leave a run in progress for the next length setting
    send_run(next_marker, int'($urandom_range(1, sb.run_target(next_marker) - 1)));
    in_valid <= 1'b0;
  endtask

  bit dir_data[25]  = '{1,1,1,1,1,0,1,0,0,0,0,1,1,1,0,0,0,0,1,1,1,1,0,1,0};
  bit dir_start[25] = '{1,0,0,0,0,0,0,0,0,0,0,0,1,0,1,0,0,0,0,0,0,0,0,1,0};

  int z_tab[NUM_PHASES]    = '{0, 2, 64, 127, 5, 3, -1, -1, 1, 4};
  int o_tab[NUM_PHASES]    = '{1, 3, 64, 65, 9, 2, -1, -1, 64, 4};
  int n_tab[NUM_PHASES]    = '{130, 140, 150, 70, 140, 120, 100, 100, 80, 80};
  int pay_tab[NUM_PHASES]  = '{5, 6, 8, 6, 10, 6, 8, 8, 6, 6};
  bit calm_tab[NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

  initial begin
    int z;
    int o;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first runs of either value, block starts mid-run and runs past their length
    for (int i = 0; i < 25; i++) send_bit(dir_data[i], dir_start[i]);
    in_valid <= 1'b0;
    next_marker = 1'($urandom_range(1));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      z = (z_tab[p] < 0) ? int'($urandom_range(12)) : z_tab[p];
      o = (o_tab[p] < 0) ? int'($urandom_range(12)) : o_tab[p];
      write_lengths(arpe_pkg::CFG_W'(z), arpe_pkg::CFG_W'(o));
      calm = calm_tab[p];
      run_phase(n_tab[p], pay_tab[p]);
      calm = 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
